@@ rtl/oqkr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// oqkr_pkg
// Shared types and constants of the ordered queue with keyed removal.
// ----------------------------------------------------------------------------
package oqkr_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int MAX_RESULTS  = 16;
    localparam int FIELD_W      = 32;
    localparam int WORD_W       = 2 * FIELD_W;

    typedef enum logic [1:0] {
        K_APPEND = 2'd0,
        K_REMOVE = 2'd1,
        K_FIND   = 2'd2,
        K_LIST   = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_DONE      = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_FULL      = 3'd2,
        ST_ENTRY     = 3'd3,
        ST_EMPTY     = 3'd4
    } t_status;

endpackage

`default_nettype wire

@@ rtl/ordered_queue_keyed_remove_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Append, full, empty list and find/remove on an empty queue answer in the cycle after
//   accept. Find/remove scan from the head via the registered read; find answers on a
//   match, remove then shifts later entries down (not for a tail match); no match gives
//   NOT_FOUND. List: up to MAX_RESULTS results one per cycle. Sequential: busy drops as
//   the final result strobes, so the next beat can be taken at the edge that takes it.
// Reset (synchronous, active low) clears the fill count and control; store contents stay.
// ----------------------------------------------------------------------------
// ordered_queue_keyed_remove_top
// Arrival-ordered queue of order records with append, keyed find, keyed
// removal with compaction and full listing.
// ----------------------------------------------------------------------------
module ordered_queue_keyed_remove_top #(
    parameter int CAPACITY = oqkr_pkg::CAPACITY_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_kind,
    input  wire logic [31:0] i_order_id,
    input  wire logic [31:0] i_amount_cents,
    output logic             o_valid,
    output logic [2:0]       o_status,
    output logic [31:0]      o_entry_id,
    output logic [31:0]      o_entry_amount,
    output logic             o_last
);

    import oqkr_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_LIST
    } t_state;

    t_state               r_state;
    t_kind                r_kind;
    logic [FIELD_W-1:0]   r_id;
    logic [CW-1:0]        r_fill;
    logic [CW-1:0]        r_idx;
    logic [CW-1:0]        r_didx;
    logic [CW-1:0]        r_lim;
    logic                 r_dv;

    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [WORD_W-1:0]    rd_data;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [WORD_W-1:0]    wr_data;
    logic                 accept;
    logic                 hit;
    logic                 last_data;
    logic [CW-1:0]        lim_in;

    assign busy      = (r_state != S_IDLE);
    assign accept    = start && !busy;
    assign hit       = r_dv && (rd_data[WORD_W-1:FIELD_W] == r_id);
    assign last_data = ((r_didx + CW'(1)) == r_fill);
    assign lim_in    = (8'(r_fill) > 8'(MAX_RESULTS)) ? CW'(MAX_RESULTS) : r_fill;

    always_comb begin
        unique case (r_state)
            S_SCAN, S_SHIFT: rd_en = (r_idx < r_fill);
            S_LIST:          rd_en = (r_idx < r_lim);
            default:         rd_en = 1'b0;
        endcase
        rd_addr = r_idx[AW-1:0];
        if (r_state == S_SHIFT) begin
            wr_en   = r_dv;
            wr_addr = AW'(r_didx - CW'(1));
            wr_data = rd_data;
        end else begin
            wr_en   = accept && (t_kind'(i_kind) == K_APPEND) && (r_fill < CW'(CAPACITY));
            wr_addr = r_fill[AW-1:0];
            wr_data = {i_order_id, i_amount_cents};
        end
    end

    oqkr_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW),
        .DW    (WORD_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_dv    <= 1'b0;
            r_idx   <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            r_dv    <= rd_en;
            r_didx  <= r_idx;
            if (rd_en) begin
                r_idx <= r_idx + CW'(1);
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_kind         <= t_kind'(i_kind);
                        r_id           <= i_order_id;
                        r_idx          <= '0;
                        o_entry_id     <= '0;
                        o_entry_amount <= '0;
                        o_last         <= 1'b1;
                        unique case (t_kind'(i_kind))
                            K_APPEND: begin
                                o_valid <= 1'b1;
                                if (r_fill == CW'(CAPACITY)) begin
                                    o_status <= ST_FULL;
                                end else begin
                                    r_fill   <= r_fill + CW'(1);
                                    o_status <= ST_DONE;
                                end
                            end
                            K_REMOVE, K_FIND: begin
                                if (r_fill == '0) begin
                                    o_valid  <= 1'b1;
                                    o_status <= ST_NOT_FOUND;
                                end else begin
                                    r_state <= S_SCAN;
                                end
                            end
                            K_LIST: begin
                                r_lim <= lim_in;
                                if (r_fill == '0) begin
                                    o_valid  <= 1'b1;
                                    o_status <= ST_EMPTY;
                                end else begin
                                    r_state <= S_LIST;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_SCAN: begin
                    if (hit) begin
                        if (r_kind == K_FIND) begin
                            o_valid        <= 1'b1;
                            o_status       <= ST_ENTRY;
                            o_entry_id     <= rd_data[WORD_W-1:FIELD_W];
                            o_entry_amount <= rd_data[FIELD_W-1:0];
                            o_last         <= 1'b1;
                            r_state        <= S_IDLE;
                        end else if (last_data) begin
                            r_fill   <= r_fill - CW'(1);
                            o_valid  <= 1'b1;
                            o_status <= ST_DONE;
                            o_last   <= 1'b1;
                            r_state  <= S_IDLE;
                        end else begin
                            r_idx   <= r_didx + CW'(1);
                            r_dv    <= 1'b0;
                            r_state <= S_SHIFT;
                        end
                    end else if (r_dv && last_data) begin
                        o_valid  <= 1'b1;
                        o_status <= ST_NOT_FOUND;
                        o_last   <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                S_SHIFT: begin
                    if (r_dv && last_data) begin
                        r_fill   <= r_fill - CW'(1);
                        o_valid  <= 1'b1;
                        o_status <= ST_DONE;
                        o_last   <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                S_LIST: begin
                    if (r_dv) begin
                        o_valid        <= 1'b1;
                        o_status       <= ST_ENTRY;
                        o_entry_id     <= rd_data[WORD_W-1:FIELD_W];
                        o_entry_amount <= rd_data[FIELD_W-1:0];
                        o_last         <= ((r_didx + CW'(1)) == r_lim);
                        if ((r_didx + CW'(1)) == r_lim) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(CAPACITY))
        else $error("fill count above capacity");

    a_no_rw_collide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(wr_en && rd_en && (wr_addr == rd_addr)))
        else $error("read and write to the same entry");

    a_mid_beat_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> (r_state == S_LIST))
        else $error("non-final beat outside a listing");

    a_shift_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT && r_dv && last_data) |=> (o_valid && o_last))
        else $error("compaction ended without a result");
`endif

endmodule

`default_nettype wire

@@ rtl/oqkr_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// oqkr_ram
// Record store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module oqkr_ram #(
    parameter int DEPTH = oqkr_pkg::CAPACITY_DEF,
    parameter int AW    = 4,
    parameter int DW    = oqkr_pkg::WORD_W
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [DW-1:0] i_wr_data,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output logic      [DW-1:0] o_rd_data
);

    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire
